>>> design/mcm_pkg.sv
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared widths, constants, codes and stage bundles of the mecanum mixer.
// ----------------------------------------------------------------------------
package mcm_pkg;

    localparam int StickW     = 11;
    localparam int KeyW       = 16;
    localparam int ModeW      = 2;
    localparam int SpeedW     = 8;
    localparam int CfgIdxW    = 3;
    localparam int AxisW      = 12;
    localparam int MagW       = 11;
    localparam int SumW       = 13;
    localparam int ProdW      = 19;
    localparam int TopW       = 10;
    localparam int NumW       = 21;
    localparam int QW         = 10;
    localparam int DivW       = 22;
    localparam int MixW       = 16;
    localparam int WheelW     = 15;
    localparam int Lanes      = 3;

    localparam int Center     = 1024;
    localparam int KeyStep    = 660;
    localparam int RecipW     = 20;
    localparam int Recip      = 813441;
    localparam int RecipShift = 29;

    localparam int StepsPerStage = 2;
    localparam int DivStages     = QW / StepsPerStage;
    localparam int PipeDepth     = 5 + DivStages + 1;

    localparam int LaneStrafe  = 0;
    localparam int LaneForward = 1;
    localparam int LaneTurn    = 2;

    localparam int KeyW_Fwd   = 0;
    localparam int KeyS_Back  = 1;
    localparam int KeyA_Left  = 2;
    localparam int KeyD_Right = 3;
    localparam int KeyShift   = 4;
    localparam int KeyCtrl    = 5;
    localparam int KeyQ_Ccw   = 6;
    localparam int KeyE_Cw    = 7;

    localparam logic [ModeW-1:0] ModeFast   = 2'd1;
    localparam logic [ModeW-1:0] ModeSlow   = 2'd2;
    localparam logic [ModeW-1:0] ModeMedium = 2'd3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SWITCH_ONE   = 3'd0,
        CFG_SWITCH_THREE = 3'd1,
        CFG_SWITCH_TWO   = 3'd2,
        CFG_DEFAULT      = 3'd3,
        CFG_SLOW_KEY     = 3'd4,
        CFG_FAST_KEY     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [SpeedW-1:0] switch_one;
        logic [SpeedW-1:0] switch_three;
        logic [SpeedW-1:0] switch_two;
        logic [SpeedW-1:0] dflt;
        logic [SpeedW-1:0] slow_key;
        logic [SpeedW-1:0] fast_key;
    } speed_cfg_t;

    typedef struct packed {
        logic [Lanes-1:0]           neg;
        logic [Lanes-1:0][MagW-1:0] mag;
        logic [MagW-1:0]            peak;
        logic [SumW-1:0]            sum;
        logic [SpeedW-1:0]          speed;
    } mag_t;

    typedef struct packed {
        logic [Lanes-1:0][DivW-1:0] rem;
        logic [Lanes-1:0][QW-1:0]   quo;
        logic [Lanes-1:0]           neg;
        logic [DivW-1:0]            dsr;
        logic                       sum_zero;
    } div_bus_t;

endpackage

>>> design/mecanum_chassis_mixer.sv
// One frame per cycle while the output is not stalled. Depth is set by the ten-bit
// restoring divider, two quotient bits per stage. The whole pipeline advances
// together; a stalled output holds every stage.
// Reset clears all valid bits and loads the speed registers with their defaults.
// ----------------------------------------------------------------------------
// mecanum_chassis_mixer
// Remote-control frame to four mecanum wheel speed targets, fully pipelined.
// ----------------------------------------------------------------------------
module mecanum_chassis_mixer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mcm_pkg::StickW-1:0]          stick_strafe,
    input  logic [mcm_pkg::StickW-1:0]          stick_forward,
    input  logic [mcm_pkg::StickW-1:0]          stick_turn,
    input  logic [mcm_pkg::ModeW-1:0]           mode_switch,
    input  logic [mcm_pkg::KeyW-1:0]            key_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mcm_pkg::WheelW-1:0]   wheel_one_target,
    output logic signed [mcm_pkg::WheelW-1:0]   wheel_two_target,
    output logic signed [mcm_pkg::WheelW-1:0]   wheel_three_target,
    output logic signed [mcm_pkg::WheelW-1:0]   wheel_four_target,
    input  logic                                cfg_we,
    input  logic [mcm_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [mcm_pkg::SpeedW-1:0]          cfg_data
);
    import mcm_pkg::*;

    logic                 en;
    logic [PipeDepth-1:0] vld_reg, vld_next;
    speed_cfg_t           cfg_reg, cfg_next;
    mag_t                 mag;
    div_bus_t             div_bus [DivStages+1];

    assign en       = !vld_reg[PipeDepth-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[PipeDepth-1];
    assign vld_next = {vld_reg[PipeDepth-2:0], in_valid};

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SWITCH_ONE:   cfg_next.switch_one   = cfg_data;
                CFG_SWITCH_THREE: cfg_next.switch_three = cfg_data;
                CFG_SWITCH_TWO:   cfg_next.switch_two   = cfg_data;
                CFG_DEFAULT:      cfg_next.dflt         = cfg_data;
                CFG_SLOW_KEY:     cfg_next.slow_key     = cfg_data;
                CFG_FAST_KEY:     cfg_next.fast_key     = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg              <= '0;
            cfg_reg.switch_one   <= SpeedW'(160);
            cfg_reg.switch_three <= SpeedW'(90);
            cfg_reg.switch_two   <= SpeedW'(50);
            cfg_reg.dflt         <= SpeedW'(80);
            cfg_reg.slow_key     <= SpeedW'(50);
            cfg_reg.fast_key     <= SpeedW'(160);
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (en)
            begin
                vld_reg <= vld_next;
            end
        end
    end

    mcm_front u_front (
        .clk           (clk),
        .en            (en),
        .stick_strafe  (stick_strafe),
        .stick_forward (stick_forward),
        .stick_turn    (stick_turn),
        .mode_switch   (mode_switch),
        .key_word      (key_word),
        .speed_cfg     (cfg_reg),
        .mag           (mag)
    );

    mcm_scale u_scale (
        .clk (clk),
        .en  (en),
        .mag (mag),
        .bus (div_bus[0])
    );

    for (genvar g = 0; g < DivStages; g++)
    begin : g_div
        mcm_div_stage u_div (
            .clk     (clk),
            .en      (en),
            .bus_in  (div_bus[g]),
            .bus_out (div_bus[g+1])
        );
    end

    mcm_mix u_mix (
        .clk                (clk),
        .en                 (en),
        .bus                (div_bus[DivStages]),
        .wheel_one_target   (wheel_one_target),
        .wheel_two_target   (wheel_two_target),
        .wheel_three_target (wheel_three_target),
        .wheel_four_target  (wheel_four_target)
    );

endmodule

>>> design/mcm_front.sv
// ----------------------------------------------------------------------------
// mcm_front
// Speed select, stick centring with key pushes, then magnitudes, peak, sum.
// ----------------------------------------------------------------------------
module mcm_front (
    input  logic                        clk,
    input  logic                        en,
    input  logic [mcm_pkg::StickW-1:0]  stick_strafe,
    input  logic [mcm_pkg::StickW-1:0]  stick_forward,
    input  logic [mcm_pkg::StickW-1:0]  stick_turn,
    input  logic [mcm_pkg::ModeW-1:0]   mode_switch,
    input  logic [mcm_pkg::KeyW-1:0]    key_word,
    input  mcm_pkg::speed_cfg_t         speed_cfg,
    output mcm_pkg::mag_t               mag
);
    import mcm_pkg::*;

    function automatic logic signed [AxisW-1:0] axis_value(
        input logic [StickW-1:0] ch,
        input logic              up,
        input logic              down
    );
        logic signed [AxisW-1:0] base;
        base = $signed({1'b0, ch}) - $signed(AxisW'(Center));
        if (up && !down)
        begin
            axis_value = base + $signed(AxisW'(KeyStep));
        end
        else if (down && !up)
        begin
            axis_value = base - $signed(AxisW'(KeyStep));
        end
        else
        begin
            axis_value = base;
        end
    endfunction

    function automatic logic [MagW-1:0] magnitude(input logic signed [AxisW-1:0] v);
        logic signed [AxisW-1:0] a;
        a = v[AxisW-1] ? -v : v;
        magnitude = a[MagW-1:0];
    endfunction

    logic signed [Lanes-1:0][AxisW-1:0] axis_reg, axis_next;
    logic [SpeedW-1:0]                  speed_reg, speed_next;
    mag_t                               mag_reg, mag_next;

    always_comb
    begin
        case (mode_switch)
            ModeFast:   speed_next = speed_cfg.switch_one;
            ModeMedium: speed_next = speed_cfg.switch_three;
            ModeSlow:   speed_next = speed_cfg.switch_two;
            default:    speed_next = speed_cfg.dflt;
        endcase
        if (key_word[KeyCtrl])
        begin
            speed_next = speed_cfg.slow_key;
        end
        if (key_word[KeyShift])
        begin
            speed_next = speed_cfg.fast_key;
        end
        axis_next[LaneStrafe]  = axis_value(stick_strafe, key_word[KeyD_Right],
                                            key_word[KeyA_Left]);
        axis_next[LaneForward] = axis_value(stick_forward, key_word[KeyW_Fwd],
                                            key_word[KeyS_Back]);
        axis_next[LaneTurn]    = axis_value(stick_turn, key_word[KeyE_Cw],
                                            key_word[KeyQ_Ccw]);
    end

    always_comb
    begin
        for (int l = 0; l < Lanes; l++)
        begin
            mag_next.neg[l] = axis_reg[l][AxisW-1];
            mag_next.mag[l] = magnitude(axis_reg[l]);
        end
        mag_next.peak = mag_next.mag[0];
        for (int l = 1; l < Lanes; l++)
        begin
            if (mag_next.mag[l] > mag_next.peak)
            begin
                mag_next.peak = mag_next.mag[l];
            end
        end
        mag_next.sum = SumW'(mag_next.mag[0]) + SumW'(mag_next.mag[1])
                     + SumW'(mag_next.mag[2]);
        mag_next.speed = speed_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            axis_reg  <= axis_next;
            speed_reg <= speed_next;
            mag_reg   <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

>>> design/mcm_scale.sv
// ----------------------------------------------------------------------------
// mcm_scale
// Peak times speed, divide by the key step via reciprocal, form numerators.
// ----------------------------------------------------------------------------
module mcm_scale (
    input  logic                clk,
    input  logic                en,
    input  mcm_pkg::mag_t       mag,
    output mcm_pkg::div_bus_t   bus
);
    import mcm_pkg::*;

    logic [ProdW-1:0]        prod_reg, prod_next;
    mag_t                    mag_c_reg;
    logic [ProdW+RecipW-1:0] scaled;
    logic [TopW-1:0]         top_reg, top_next;
    mag_t                    mag_d_reg;
    div_bus_t                bus_reg, bus_next;
    logic [NumW-1:0]         num;

    assign prod_next = ProdW'(mag.peak) * ProdW'(mag.speed);
    assign scaled    = (ProdW+RecipW)'(prod_reg) * (ProdW+RecipW)'(Recip);
    assign top_next  = scaled[RecipShift +: TopW];

    always_comb
    begin
        bus_next = '0;
        for (int l = 0; l < Lanes; l++)
        begin
            num               = NumW'(mag_d_reg.mag[l]) * NumW'(top_reg);
            bus_next.rem[l]   = DivW'(num);
            bus_next.quo[l]   = '0;
        end
        bus_next.neg      = mag_d_reg.neg;
        bus_next.dsr      = DivW'(mag_d_reg.sum) << (QW - 1);
        bus_next.sum_zero = (mag_d_reg.sum == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            mag_c_reg <= mag;
            top_reg   <= top_next;
            mag_d_reg <= mag_c_reg;
            bus_reg   <= bus_next;
        end
    end

    assign bus = bus_reg;

endmodule

>>> design/mcm_div_stage.sv
// ----------------------------------------------------------------------------
// mcm_div_stage
// Restoring division, two quotient bits per stage, three lanes in step.
// ----------------------------------------------------------------------------
module mcm_div_stage (
    input  logic                clk,
    input  logic                en,
    input  mcm_pkg::div_bus_t   bus_in,
    output mcm_pkg::div_bus_t   bus_out
);
    import mcm_pkg::*;

    div_bus_t bus_reg, bus_next;

    always_comb
    begin
        bus_next = bus_in;
        for (int s = 0; s < StepsPerStage; s++)
        begin
            for (int l = 0; l < Lanes; l++)
            begin
                if (bus_next.rem[l] >= bus_next.dsr)
                begin
                    bus_next.rem[l] = bus_next.rem[l] - bus_next.dsr;
                    bus_next.quo[l] = {bus_next.quo[l][QW-2:0], 1'b1};
                end
                else
                begin
                    bus_next.quo[l] = {bus_next.quo[l][QW-2:0], 1'b0};
                end
            end
            bus_next.dsr = bus_next.dsr >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

>>> design/mcm_mix.sv
// ----------------------------------------------------------------------------
// mcm_mix
// Restore signs, mix into four wheel targets, scale by the wheel gain.
// ----------------------------------------------------------------------------
module mcm_mix (
    input  logic                                clk,
    input  logic                                en,
    input  mcm_pkg::div_bus_t                   bus,
    output logic signed [mcm_pkg::WheelW-1:0]   wheel_one_target,
    output logic signed [mcm_pkg::WheelW-1:0]   wheel_two_target,
    output logic signed [mcm_pkg::WheelW-1:0]   wheel_three_target,
    output logic signed [mcm_pkg::WheelW-1:0]   wheel_four_target
);
    import mcm_pkg::*;

    function automatic logic signed [MixW-1:0] times_gain(input logic signed [MixW-1:0] v);
        times_gain = (v <<< 4) + (v <<< 1) + v;
    endfunction

    logic signed [Lanes-1:0][MixW-1:0] val;
    logic signed [MixW-1:0]            f, s, t;
    logic signed [MixW-1:0]            w1, w2, w3, w4;
    logic signed [WheelW-1:0]          w1_reg, w2_reg, w3_reg, w4_reg;

    always_comb
    begin
        for (int l = 0; l < Lanes; l++)
        begin
            if (bus.sum_zero)
            begin
                val[l] = '0;
            end
            else if (bus.neg[l])
            begin
                val[l] = -$signed(MixW'(bus.quo[l]));
            end
            else
            begin
                val[l] = $signed(MixW'(bus.quo[l]));
            end
        end
        s  = val[LaneStrafe];
        f  = val[LaneForward];
        t  = val[LaneTurn];
        w1 = times_gain(f + s + t);
        w2 = times_gain(s + t - f);
        w3 = times_gain(f - s + t);
        w4 = times_gain(t - f - s);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg <= w1[WheelW-1:0];
            w2_reg <= w2[WheelW-1:0];
            w3_reg <= w3[WheelW-1:0];
            w4_reg <= w4[WheelW-1:0];
        end
    end

    assign wheel_one_target   = w1_reg;
    assign wheel_two_target   = w2_reg;
    assign wheel_three_target = w3_reg;
    assign wheel_four_target  = w4_reg;

endmodule

>>> tb/tb_mecanum_chassis_mixer.sv
// ----------------------------------------------------------------------------
// tb_mecanum_chassis_mixer
// Self-checking bench for the mecanum wheel mixer. Frames go in through a
// valid/ready channel with random gaps. A scoreboard predicts the four wheel
// targets of every accepted frame under the speed levels last written. It
// compares each result transfer, field by field, in order. The speed
// registers are rewritten between phases, and only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_mecanum_chassis_mixer;

    timeunit 1ns;
    timeprecision 1ps;

    import mcm_pkg::*;

    localparam int WheelGain  = 19;
    localparam int StallLimit = 2000;
    localparam int StickMax   = (1 << StickW) - 1;

    typedef struct packed {
        logic [StickW-1:0] strafe;
        logic [StickW-1:0] forward;
        logic [StickW-1:0] turn;
        logic [ModeW-1:0]  mode;
        logic [KeyW-1:0]   keys;
    } frame_t;

    typedef struct {
        logic signed [WheelW-1:0] one;
        logic signed [WheelW-1:0] two;
        logic signed [WheelW-1:0] three;
        logic signed [WheelW-1:0] four;
    } wheel_set_t;

    class wheel_scoreboard;
        speed_cfg_t speeds;
        wheel_set_t wheel_q[$];
        int         errors;
        int         frames;
        int         results;

        function new();
            speeds.switch_one   = SpeedW'(160);
            speeds.switch_three = SpeedW'(90);
            speeds.switch_two   = SpeedW'(50);
            speeds.dflt         = SpeedW'(80);
            speeds.slow_key     = SpeedW'(50);
            speeds.fast_key     = SpeedW'(160);
            errors  = 0;
            frames  = 0;
            results = 0;
        endfunction

        function automatic wheel_set_t mix_frame(frame_t fr);
            wheel_set_t w;
            logic [SpeedW-1:0] speed;
            int x, y, z, ax, ay, az, peak, sum, top, f, s, t;
            case (fr.mode)
                ModeFast:   speed = speeds.switch_one;
                ModeMedium: speed = speeds.switch_three;
                ModeSlow:   speed = speeds.switch_two;
                default:    speed = speeds.dflt;
            endcase
            if (fr.keys[KeyCtrl])
                speed = speeds.slow_key;
            if (fr.keys[KeyShift])
                speed = speeds.fast_key;
            x = int'(fr.strafe) - Center
                + (int'(fr.keys[KeyD_Right]) - int'(fr.keys[KeyA_Left])) * KeyStep;
            y = int'(fr.forward) - Center
                + (int'(fr.keys[KeyW_Fwd]) - int'(fr.keys[KeyS_Back])) * KeyStep;
            z = int'(fr.turn) - Center
                + (int'(fr.keys[KeyE_Cw]) - int'(fr.keys[KeyQ_Ccw])) * KeyStep;
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            az = (z < 0) ? -z : z;
            peak = ax;
            if (ay > peak)
                peak = ay;
            if (az > peak)
                peak = az;
            top = (peak * int'(speed)) / KeyStep;
            sum = ax + ay + az;
            f = 0;
            s = 0;
            t = 0;
            if (sum != 0)
            begin
                f = (y * top) / sum;
                s = (x * top) / sum;
                t = (z * top) / sum;
            end
            w.one   = WheelW'(WheelGain * (f + s + t));
            w.two   = WheelW'(-WheelGain * (f - s - t));
            w.three = WheelW'(WheelGain * (f - s + t));
            w.four  = WheelW'(-WheelGain * (f + s - t));
            return w;
        endfunction

        function void note_frame(frame_t fr);
            wheel_q.push_back(mix_frame(fr));
            frames++;
        endfunction

        function int pending();
            return wheel_q.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH result %0d: %s", $time, results, what);
            errors++;
        endtask

        task check_wheels(wheel_set_t got);
            wheel_set_t want;
            if (wheel_q.size() == 0)
            begin
                report_mismatch("result transfer with no frame outstanding");
                return;
            end
            want = wheel_q.pop_front();
            if (got.one !== want.one)
                report_mismatch($sformatf("wheel one %0d, want %0d", got.one, want.one));
            if (got.two !== want.two)
                report_mismatch($sformatf("wheel two %0d, want %0d", got.two, want.two));
            if (got.three !== want.three)
                report_mismatch($sformatf("wheel three %0d, want %0d", got.three, want.three));
            if (got.four !== want.four)
                report_mismatch($sformatf("wheel four %0d, want %0d", got.four, want.four));
            results++;
        endtask
    endclass

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_ready;
    logic [StickW-1:0]        stick_strafe  = '0;
    logic [StickW-1:0]        stick_forward = '0;
    logic [StickW-1:0]        stick_turn    = '0;
    logic [ModeW-1:0]         mode_switch   = '0;
    logic [KeyW-1:0]          key_word      = '0;
    logic                     out_valid;
    logic                     out_ready     = 1'b0;
    logic signed [WheelW-1:0] wheel_one_target;
    logic signed [WheelW-1:0] wheel_two_target;
    logic signed [WheelW-1:0] wheel_three_target;
    logic signed [WheelW-1:0] wheel_four_target;
    logic                     cfg_we        = 1'b0;
    logic [CfgIdxW-1:0]       cfg_index     = '0;
    logic [SpeedW-1:0]        cfg_data      = '0;

    wheel_scoreboard sb = new();
    int              stall_pct    = 0;
    int              quiet_cycles = 0;
    int              settings     = 1;

    mecanum_chassis_mixer i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .stick_strafe       (stick_strafe),
        .stick_forward      (stick_forward),
        .stick_turn         (stick_turn),
        .mode_switch        (mode_switch),
        .key_word           (key_word),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .wheel_one_target   (wheel_one_target),
        .wheel_two_target   (wheel_two_target),
        .wheel_three_target (wheel_three_target),
        .wheel_four_target  (wheel_four_target),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #5 clk = ~clk;

    // hold off the result side in random bursts
    always @(posedge clk)
    begin
        if (rst_n && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        frame_t     fr;
        wheel_set_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.one   = wheel_one_target;
                got.two   = wheel_two_target;
                got.three = wheel_three_target;
                got.four  = wheel_four_target;
                sb.check_wheels(got);
            end
            if (in_valid && in_ready)
            begin
                fr.strafe  = stick_strafe;
                fr.forward = stick_forward;
                fr.turn    = stick_turn;
                fr.mode    = mode_switch;
                fr.keys    = key_word;
                sb.note_frame(fr);
            end
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= StallLimit)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $time, StallLimit);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic frame_t make_frame(int strafe, int forward, int turn, int mode,
                                          int keys);
        frame_t fr;
        fr.strafe  = StickW'(strafe);
        fr.forward = StickW'(forward);
        fr.turn    = StickW'(turn);
        fr.mode    = ModeW'(mode);
        fr.keys    = KeyW'(keys);
        return fr;
    endfunction

    function automatic logic [StickW-1:0] random_stick();
        logic [StickW-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = StickW'(StickMax);
            2:       v = StickW'(Center);
            3:       v = StickW'($urandom_range(Center - 8, Center + 8));
            4:       v = StickW'($urandom_range(0, 1) ? Center - KeyStep
                                                      : Center + KeyStep - 1);
            default: v = StickW'($urandom_range(0, StickMax));
        endcase
        return v;
    endfunction

    function automatic frame_t random_frame();
        frame_t fr;
        fr.strafe  = random_stick();
        fr.forward = random_stick();
        fr.turn    = random_stick();
        fr.mode    = ModeW'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       fr.keys = KeyW'($urandom);
            1:       fr.keys = KeyW'($urandom_range(0, 255));
            2:       fr.keys = '0;
            default: fr.keys = KeyW'(1 << $urandom_range(0, 7));
        endcase
        // centred sticks, speed keys only
        if ($urandom_range(0, 15) == 0)
        begin
            fr.strafe  = StickW'(Center);
            fr.forward = StickW'(Center);
            fr.turn    = StickW'(Center);
            fr.keys    = fr.keys & KeyW'((1 << KeyShift) | (1 << KeyCtrl));
        end
        return fr;
    endfunction

    function automatic speed_cfg_t random_speeds();
        speed_cfg_t c;
        c.switch_one   = SpeedW'($urandom_range(0, 255));
        c.switch_three = SpeedW'($urandom_range(0, 255));
        c.switch_two   = SpeedW'($urandom_range(0, 255));
        c.dflt         = SpeedW'($urandom_range(0, 255));
        c.slow_key     = SpeedW'($urandom_range(0, 255));
        c.fast_key     = SpeedW'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic send_frame(input frame_t fr);
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        stick_strafe  <= fr.strafe;
        stick_forward <= fr.forward;
        stick_turn    <= fr.turn;
        mode_switch   <= fr.mode;
        key_word      <= fr.keys;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [SpeedW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic write_speeds(input speed_cfg_t c);
        put_reg(CFG_SWITCH_ONE, c.switch_one);
        put_reg(CFG_SWITCH_THREE, c.switch_three);
        put_reg(CFG_SWITCH_TWO, c.switch_two);
        put_reg(CFG_DEFAULT, c.dflt);
        put_reg(CFG_SLOW_KEY, c.slow_key);
        put_reg(CFG_FAST_KEY, c.fast_key);
        cfg_we    <= 1'b0;
        sb.speeds = c;
    endtask

    task automatic run_phase(input speed_cfg_t c, input int count, input int pct);
        drain();
        write_speeds(c);
        settings++;
        stall_pct = pct;
        repeat (count) send_frame(random_frame());
    endtask

    initial
    begin
        frame_t     directed[$];
        speed_cfg_t c;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_frame(Center, Center, Center, 0, 16'h0000));
        directed.push_back(make_frame(0, 0, 0, 0, 16'h0000));
        directed.push_back(make_frame(StickMax, StickMax, StickMax, ModeFast, 16'h0000));
        directed.push_back(make_frame(0, StickMax, Center, ModeSlow, 16'h0000));
        directed.push_back(make_frame(Center, 0, StickMax, ModeMedium, 16'h0000));
        directed.push_back(make_frame(Center, Center, Center, ModeFast, 1 << KeyW_Fwd));
        directed.push_back(make_frame(Center, Center, Center, ModeFast, 1 << KeyS_Back));
        directed.push_back(make_frame(Center, Center, Center, ModeSlow, 1 << KeyA_Left));
        directed.push_back(make_frame(Center, Center, Center, ModeSlow, 1 << KeyD_Right));
        directed.push_back(make_frame(Center, Center, Center, ModeMedium, 1 << KeyQ_Ccw));
        directed.push_back(make_frame(Center, Center, Center, ModeMedium, 1 << KeyE_Cw));
        directed.push_back(make_frame(Center, Center, Center, 0, 16'h0003));
        directed.push_back(make_frame(Center, Center, Center, ModeFast, 16'h00CF));
        directed.push_back(make_frame(StickMax, 0, 1500, ModeSlow, 1 << KeyShift));
        directed.push_back(make_frame(StickMax, 0, 1500, ModeFast, 1 << KeyCtrl));
        directed.push_back(make_frame(StickMax, 0, 1500, ModeSlow, 16'h0030));
        directed.push_back(make_frame(100, 1900, 700, ModeMedium, 16'hFF00));
        directed.push_back(make_frame(0, 0, 0, 0, 16'hFFFF));
        directed.push_back(make_frame(0, 0, 0, ModeFast, 16'h0046));
        directed.push_back(make_frame(StickMax, StickMax, StickMax, ModeFast, 16'h0099));
        directed.push_back(make_frame(Center - KeyStep, Center, Center, 0, 1 << KeyD_Right));
        directed.push_back(make_frame(1, 2046, Center, ModeMedium, 16'h0000));

        stall_pct = 15;
        foreach (directed[i])
            send_frame(directed[i]);

        c = '0;
        run_phase(c, 300, 20);
        c = '1;
        run_phase(c, 400, 40);
        run_phase(random_speeds(), 400, 10);
        run_phase(random_speeds(), 400, 25);
        run_phase(random_speeds(), 400, 0);

        drain();
        repeat (PipeDepth + 4) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("Ran %0d frames (directed corners, then random) under %0d speed settings;",
                 sb.frames, settings);
        $display("%0d wheel results checked, %0d mismatches.", sb.results, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> mecanum_chassis_mixer.f
design/mcm_pkg.sv
design/mcm_front.sv
design/mcm_scale.sv
design/mcm_div_stage.sv
design/mcm_mix.sv
design/mecanum_chassis_mixer.sv
tb/tb_mecanum_chassis_mixer.sv
